// File: rtl/aml_s5_sleep_type_extractor_defines.svh
// Assertion macros for the sleep-type extractor.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef AML_S5_SLEEP_TYPE_EXTRACTOR_DEFINES_SVH
`define AML_S5_SLEEP_TYPE_EXTRACTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define S5X_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s5x check failed");
`define S5X_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s5x check failed");
`else
`define S5X_ASSERT_NOW(label, ante, cons)
`define S5X_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/s5x_pkg.sv
// Shared types and constants for the sleep-type extractor.
// No dependencies.
package s5x_pkg;

  localparam int HEADER_BYTES_DEFAULT = 36;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NO_NAME   = 2'd1;
  localparam logic [1:0] ST_NOT_PKG   = 2'd2;
  localparam logic [1:0] ST_EARLY_END = 2'd3;

  localparam logic [23:0] NAME_HEAD   = 24'h5F5335;
  localparam logic [7:0]  NAME_TAIL   = 8'h5F;
  localparam logic [7:0]  PACKAGE_OP  = 8'h12;
  localparam logic [7:0]  BYTE_PREFIX = 8'h0A;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_flag;
    logic       last_flag;
  } byte_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] sleep_type_a;
    logic [7:0] sleep_type_b;
  } result_item_t;

endpackage

// File: rtl/s5x_parser.sv
// Byte-wise scan of the table body: name search, package header skip, element capture.
// Depends on s5x_pkg.
module s5x_parser #(
  parameter int HEADER_BYTES = s5x_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 take,
  input  s5x_pkg::byte_item_t  item,
  output logic                 emit_valid,
  output s5x_pkg::result_item_t emit_item
);
  import s5x_pkg::*;

  localparam int OffW = (HEADER_BYTES < 1) ? 1 : $clog2(HEADER_BYTES + 1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SEARCH = 3'd1;
  localparam logic [2:0] PH_PKGOP  = 3'd2;
  localparam logic [2:0] PH_PKGLEN = 3'd3;
  localparam logic [2:0] PH_SKIP   = 3'd4;
  localparam logic [2:0] PH_ELEM_A = 3'd5;
  localparam logic [2:0] PH_ELEM_B = 3'd6;

  logic [2:0]      phase, phase_next;
  logic [23:0]     name_window, name_window_next;
  logic [OffW-1:0] offset_count, offset_count_next;
  logic [2:0]      skip_left, skip_left_next;
  logic [7:0]      type_a_hold, type_a_hold_next;

  logic [2:0]      ph_cur;
  logic [23:0]     win_cur;
  logic [OffW-1:0] off_cur;
  logic [2:0]      skip_cur;
  logic [7:0]      hold_cur;
  logic            check_last;
  logic            emit;
  logic [1:0]      emit_status;
  logic [7:0]      emit_b;
  logic [7:0]      b;

  assign b = item.data_byte;

  always_comb begin
    ph_cur   = item.first_flag ? PH_SEARCH : phase;
    win_cur  = item.first_flag ? 24'd0 : name_window;
    off_cur  = item.first_flag ? '0 : offset_count;
    skip_cur = item.first_flag ? 3'd0 : skip_left;
    hold_cur = item.first_flag ? 8'd0 : type_a_hold;

    phase_next        = ph_cur;
    name_window_next  = win_cur;
    offset_count_next = off_cur;
    skip_left_next    = skip_cur;
    type_a_hold_next  = hold_cur;
    check_last        = 1'b0;
    emit              = 1'b0;
    emit_status       = ST_FOUND;
    emit_b            = 8'd0;

    case (ph_cur)
      PH_SEARCH: begin
        if (off_cur < OffW'(HEADER_BYTES)) begin
          offset_count_next = off_cur + OffW'(1);
          name_window_next  = 24'd0;
          if (item.last_flag) begin
            emit        = 1'b1;
            emit_status = ST_NO_NAME;
          end
        end else if (win_cur == NAME_HEAD && b == NAME_TAIL && !item.last_flag) begin
          phase_next       = PH_PKGOP;
          name_window_next = 24'd0;
        end else begin
          name_window_next = {win_cur[15:0], b};
          if (item.last_flag) begin
            emit        = 1'b1;
            emit_status = ST_NO_NAME;
          end
        end
      end
      PH_PKGOP: begin
        if (b != PACKAGE_OP) begin
          emit        = 1'b1;
          emit_status = ST_NOT_PKG;
        end else begin
          phase_next = PH_PKGLEN;
          check_last = 1'b1;
        end
      end
      PH_PKGLEN: begin
        skip_left_next = {1'b0, b[7:6]} + 3'd1;
        phase_next     = PH_SKIP;
        check_last     = 1'b1;
      end
      PH_SKIP: begin
        skip_left_next = skip_cur - 3'd1;
        if (skip_cur == 3'd1) begin
          phase_next = PH_ELEM_A;
        end
        check_last = 1'b1;
      end
      PH_ELEM_A: begin
        if (skip_cur == 3'd0 && b == BYTE_PREFIX) begin
          skip_left_next = 3'd1;
        end else begin
          type_a_hold_next = b;
          skip_left_next   = 3'd0;
          phase_next       = PH_ELEM_B;
        end
        check_last = 1'b1;
      end
      PH_ELEM_B: begin
        if (skip_cur == 3'd0 && b == BYTE_PREFIX) begin
          skip_left_next = 3'd1;
          check_last     = 1'b1;
        end else begin
          skip_left_next = 3'd0;
          emit           = 1'b1;
          emit_status    = ST_FOUND;
          emit_b         = b;
        end
      end
      default: begin
      end
    endcase

    if (check_last && item.last_flag) begin
      emit        = 1'b1;
      emit_status = ST_EARLY_END;
    end
    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_SEARCH;
      name_window  <= 24'd0;
      offset_count <= '0;
      skip_left    <= 3'd0;
      type_a_hold  <= 8'd0;
    end else if (take) begin
      phase        <= phase_next;
      name_window  <= name_window_next;
      offset_count <= offset_count_next;
      skip_left    <= skip_left_next;
      type_a_hold  <= type_a_hold_next;
    end
  end

  assign emit_valid             = take && emit;
  assign emit_item.status       = emit_status;
  assign emit_item.sleep_type_a = (emit_status == ST_FOUND) ? type_a_hold_next : 8'd0;
  assign emit_item.sleep_type_b = emit_b;

endmodule

// File: rtl/s5x_out_buf.sv
// Result register with one skid entry; holds results while the receiver stalls.
// Depends on s5x_pkg.
module s5x_out_buf (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  s5x_pkg::result_item_t in_item,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output s5x_pkg::result_item_t out_item
);
  import s5x_pkg::*;

  logic         skid_valid;
  result_item_t skid_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      out_item <= skid_valid ? skid_item : in_item;
    end else if (in_valid) begin
      skid_item <= in_item;
    end
  end

  assign full = skid_valid;

endmodule

// File: rtl/aml_s5_sleep_type_extractor.sv
// Top level of the ACPI _S5_ sleep-type extractor: byte scanner and result buffer.
// Depends on s5x_pkg, s5x_parser, s5x_out_buf and the assertion macro header.
//
//   channel  direction  handshake                    item
//   byte     in         byte_valid / byte_stall      byte_item_t (one table byte, flags)
//   result   out        result_valid / result_stall  result_item_t (status, two types)
//
// One byte per cycle while byte_stall is low; the scan state updates in the cycle a byte is taken.
// The result a byte decides is registered in the result buffer, or in its skid entry while the receiver stalls.
// Reset leaves the scanner at table offset 0; no clearing pass.
// byte_stall rises only when a result and a skid result both wait.
`include "aml_s5_sleep_type_extractor_defines.svh"

module aml_s5_sleep_type_extractor #(
  parameter int HEADER_BYTES = s5x_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_stall,
  input  s5x_pkg::byte_item_t   byte_item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output s5x_pkg::result_item_t result_item
);
  import s5x_pkg::*;

  logic         take;
  logic         emit_valid;
  result_item_t emit_item;
  logic         res_other;
  logic         res_types_zero;

  assign take = byte_valid && !byte_stall;

  s5x_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (byte_item),
    .emit_valid(emit_valid),
    .emit_item (emit_item)
  );

  s5x_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (emit_valid),
    .in_item  (emit_item),
    .full     (byte_stall),
    .out_valid(result_valid),
    .out_stall(result_stall),
    .out_item (result_item)
  );

  assign res_other      = result_valid && result_item.status != ST_FOUND;
  assign res_types_zero = result_item.sleep_type_a == 8'd0 && result_item.sleep_type_b == 8'd0;

  `S5X_ASSERT_NOW(a_zero_types, res_other, res_types_zero)
  `S5X_ASSERT_NOW(a_stall_needs_result, byte_stall, result_valid)
  `S5X_ASSERT_NOW(a_stall_cause, $rose(byte_stall), $past(result_valid && result_stall && emit_valid))

endmodule

// File: tb/s5x_scan_checker.sv
// Checker for the sleep-type extractor: watches the byte and result channels,
// tracks the table scan on its own and compares every result taken.
// Depends on s5x_pkg.
module s5x_scan_checker #(
  parameter int HEADER_BYTES = s5x_pkg::HEADER_BYTES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  input  logic                  byte_stall,
  input  s5x_pkg::byte_item_t   byte_item,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  s5x_pkg::result_item_t result_item,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import s5x_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_SEARCH,
    SCAN_PKGOP,
    SCAN_PKGLEN,
    SCAN_SKIP,
    SCAN_ELEM_A,
    SCAN_ELEM_B
  } scan_phase_e;

  scan_phase_e  scan_phase;
  logic [23:0]  name_window;
  logic [5:0]   header_seen;
  logic [2:0]   skip_left;
  logic [7:0]   held_type_a;
  result_item_t due_results[$];

  task automatic log_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic restart_scan();
    scan_phase  = SCAN_SEARCH;
    name_window = '0;
    header_seen = '0;
    skip_left   = '0;
    held_type_a = '0;
  endtask

  task automatic post_result(input logic [1:0] st, input logic [7:0] a, input logic [7:0] b);
    result_item_t r;
    r.status       = st;
    r.sleep_type_a = a;
    r.sleep_type_b = b;
    due_results.push_back(r);
    scan_phase = SCAN_IDLE;
  endtask

  task automatic track_scan(input byte_item_t it);
    logic [7:0] b;
    logic       settled;
    b = it.data_byte;
    settled = 1'b0;
    if (it.first_flag) restart_scan();
    case (scan_phase)
      SCAN_SEARCH: begin
        settled = 1'b1;
        if (header_seen < HEADER_BYTES) begin
          header_seen = header_seen + 6'd1;
          name_window = '0;
        end else if (name_window == NAME_HEAD && b == NAME_TAIL && !it.last_flag) begin
          scan_phase  = SCAN_PKGOP;
          name_window = '0;
        end else begin
          name_window = {name_window[15:0], b};
        end
        if (it.last_flag && scan_phase == SCAN_SEARCH) post_result(ST_NO_NAME, 8'h00, 8'h00);
      end
      SCAN_PKGOP: begin
        if (b != PACKAGE_OP) begin
          post_result(ST_NOT_PKG, 8'h00, 8'h00);
          settled = 1'b1;
        end else begin
          scan_phase = SCAN_PKGLEN;
        end
      end
      SCAN_PKGLEN: begin
        skip_left  = {1'b0, b[7:6]} + 3'd1;
        scan_phase = SCAN_SKIP;
      end
      SCAN_SKIP: begin
        skip_left = skip_left - 3'd1;
        if (skip_left == 3'd0) scan_phase = SCAN_ELEM_A;
      end
      SCAN_ELEM_A: begin
        if (skip_left == 3'd0 && b == BYTE_PREFIX) begin
          skip_left = 3'd1;
        end else begin
          held_type_a = b;
          skip_left   = 3'd0;
          scan_phase  = SCAN_ELEM_B;
        end
      end
      SCAN_ELEM_B: begin
        if (skip_left == 3'd0 && b == BYTE_PREFIX) begin
          skip_left = 3'd1;
        end else begin
          skip_left = 3'd0;
          post_result(ST_FOUND, held_type_a, b);
          settled = 1'b1;
        end
      end
      default: settled = 1'b1;
    endcase
    if (!settled && it.last_flag) post_result(ST_EARLY_END, 8'h00, 8'h00);
  endtask

  always @(posedge clk) begin
    result_item_t want;
    if (rst) begin
      restart_scan();
      due_results.delete();
      fail_count = 0;
      pending <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result %p", result_item));
        end else begin
          want = due_results.pop_front();
          if (result_item.status !== want.status)
            log_mismatch($sformatf("status %0d, want %0d", result_item.status, want.status));
          if (result_item.sleep_type_a !== want.sleep_type_a)
            log_mismatch($sformatf("sleep_type_a %02h, want %02h",
                                   result_item.sleep_type_a, want.sleep_type_a));
          if (result_item.sleep_type_b !== want.sleep_type_b)
            log_mismatch($sformatf("sleep_type_b %02h, want %02h",
                                   result_item.sleep_type_b, want.sleep_type_b));
        end
      end
      if (byte_valid && !byte_stall) track_scan(byte_item);
      pending <= due_results.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the sleep-type extractor testbench: clock, reset, table byte stimulus,
// random result back-pressure and the verdict.
// Depends on s5x_pkg, aml_s5_sleep_type_extractor and s5x_scan_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import s5x_pkg::*;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int TABLE_ITEMS   = 700;
  localparam int HOLD_CYCLES   = 300;

  typedef enum int {
    TBL_FOUND,
    TBL_TRUNCATED,
    TBL_NOT_PKG,
    TBL_NAME_AT_END,
    TBL_NO_NAME,
    TBL_SHORT,
    TBL_NOISE
  } table_kind_e;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         byte_valid = 1'b0;
  logic         byte_stall;
  byte_item_t   byte_item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;
  int           fail_count;
  int           pending;
  int           cycle_count = 0;
  int           table_items = 0;
  logic         hold_off_req = 1'b0;
  bit           gaps_on = 1'b1;
  logic [7:0]   table_q[$];

  aml_s5_sleep_type_extractor u_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  s5x_scan_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** aml_s5_sleep_type_extractor: FAILED **");
      $finish;
    end
  end

  // result back-pressure: short and long stalls, quiet stretches, one long hold-off
  initial begin : stall_driver
    int  r;
    int  n;
    bit  held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          result_stall <= 1'b0;
          n = $urandom_range(1, 12);
        end else if (r < 55) begin
          result_stall <= 1'b0;
          n = $urandom_range(40, 120);
        end else if (r < 92) begin
          result_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          result_stall <= 1'b1;
          n = $urandom_range(15, 50);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input int gap);
    byte_valid <= 1'b1;
    byte_item  <= '{data_byte: b, first_flag: first, last_flag: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic void push_random(input int n);
    repeat (n) table_q.push_back(8'($urandom));
  endfunction

  function automatic void push_name();
    table_q.push_back(NAME_HEAD[23:16]);
    table_q.push_back(NAME_HEAD[15:8]);
    table_q.push_back(NAME_HEAD[7:0]);
    table_q.push_back(NAME_TAIL);
  endfunction

  function automatic void push_element();
    case ($urandom_range(0, 3))
      0: table_q.push_back(8'($urandom));
      1: begin
        table_q.push_back(BYTE_PREFIX);
        table_q.push_back(8'($urandom));
      end
      2: begin
        table_q.push_back(BYTE_PREFIX);
        table_q.push_back(BYTE_PREFIX);
      end
      default: table_q.push_back($urandom_range(0, 7) == 0 ? BYTE_PREFIX : 8'($urandom));
    endcase
  endfunction

  function automatic void build_table(input table_kind_e kind);
    logic [7:0] lead;
    logic [7:0] op;
    int         cut;
    table_q.delete();
    if (kind == TBL_SHORT) begin
      push_random($urandom_range(1, HEADER_BYTES_DEFAULT));
      return;
    end
    push_random(HEADER_BYTES_DEFAULT);
    // a name inside the header must not count
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, HEADER_BYTES_DEFAULT - 4);
      table_q[cut]     = NAME_HEAD[23:16];
      table_q[cut + 1] = NAME_HEAD[15:8];
      table_q[cut + 2] = NAME_HEAD[7:0];
      table_q[cut + 3] = NAME_TAIL;
    end
    push_random($urandom_range(0, 6));
    if (kind == TBL_NO_NAME) begin
      push_random($urandom_range(1, 20));
      return;
    end
    push_name();
    if (kind == TBL_NAME_AT_END) return;
    if (kind == TBL_NOT_PKG) begin
      op = 8'($urandom);
      if (op == PACKAGE_OP) op = ~op;
      table_q.push_back(op);
    end else begin
      table_q.push_back(PACKAGE_OP);
      lead = 8'($urandom);
      table_q.push_back(lead);
      push_random(int'(lead[7:6]));
      table_q.push_back(8'($urandom_range(0, 3)));
      push_element();
      push_element();
    end
    if ($urandom_range(0, 3) == 0) push_name();
    push_random($urandom_range(0, 5));
    if (kind == TBL_TRUNCATED) begin
      cut = $urandom_range(HEADER_BYTES_DEFAULT + 1, table_q.size() - 1);
      while (table_q.size() > cut) void'(table_q.pop_back());
    end
  endfunction

  task automatic send_table(input bit with_last);
    int n;
    n = table_q.size();
    for (int i = 0; i < n; i++)
      send_byte(table_q[i], i == 0, with_last && i == n - 1, pick_gap());
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n)
      send_byte(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0, pick_gap());
  endtask

  initial begin : stimulus
    int           idx;
    int           r;
    table_kind_e  kind;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bytes before any first flag, then last while still in the header
    send_byte(8'h00, 1'b0, 1'b0, 0);
    send_byte(8'hFF, 1'b0, 1'b0, 1);
    send_byte(NAME_TAIL, 1'b0, 1'b0, 0);
    send_byte(8'h35, 1'b0, 1'b1, 0);
    // ignored after a result, last flag too
    send_byte(8'hAA, 1'b0, 1'b1, 2);
    send_byte(8'h55, 1'b0, 1'b0, 0);
    send_byte(8'hFF, 1'b1, 1'b1, 0);
    // first flag mid-table restarts
    send_byte(8'h01, 1'b1, 1'b0, 0);
    send_byte(8'h02, 1'b0, 1'b0, 0);
    send_byte(8'h80, 1'b1, 1'b0, 3);
    send_byte(8'h7F, 1'b0, 1'b1, 0);
    send_byte(8'h00, 1'b1, 1'b1, 0);

    // fill the block while results are held off, then drain completely
    hold_off_req <= 1'b1;
    for (int i = 0; i < 24; i++)
      send_byte(8'($urandom), 1'b1, 1'b1, 0);
    drain_results();

    idx = 0;
    while (table_items < TABLE_ITEMS) begin
      if (idx < TBL_NOISE + 1) begin
        kind = table_kind_e'(idx);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35)      kind = TBL_FOUND;
        else if (r < 55) kind = TBL_TRUNCATED;
        else if (r < 63) kind = TBL_NOT_PKG;
        else if (r < 70) kind = TBL_NAME_AT_END;
        else if (r < 78) kind = TBL_NO_NAME;
        else if (r < 88) kind = TBL_SHORT;
        else             kind = TBL_NOISE;
      end
      gaps_on = $urandom_range(0, 2) != 0;
      if (kind == TBL_NOISE) begin
        send_noise();
      end else begin
        build_table(kind);
        table_items += table_q.size();
        send_table(kind != TBL_TRUNCATED || $urandom_range(0, 1) == 0);
      end
      if (idx == 20) drain_results();
      idx++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("** aml_s5_sleep_type_extractor: PASSED **");
    end else begin
      $display("** aml_s5_sleep_type_extractor: FAILED **");
    end
    $finish;
  end

endmodule
